### hdl/bba_pkg.sv
// bba_pkg: constants, status codes and tree-node helpers for the buddy allocator
// used by bba_need and buddy_block_allocator; no dependencies
`default_nettype none

package bba_pkg;

	localparam int MAX_LEVEL    = 10;
	localparam int UNIT_BYTES   = 1024;
	localparam int HEADER_BYTES = 16;
	localparam int UNITS        = 1 << MAX_LEVEL;
	localparam int NODES        = 2 << MAX_LEVEL;
	localparam int WORD_BITS    = 32;
	localparam int WORDS        = NODES / WORD_BITS;
	localparam int LVL_W        = 4;
	localparam int UNIT_W       = 10;
	localparam int NODE_W       = 11;
	localparam int WADDR_W      = 6;
	localparam int BIT_W        = 5;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO     = 2'd1,
		ST_NO_SPACE = 2'd2,
		ST_BAD_FREE = 2'd3
	} status_t;

	// heap-style node index of the block at (level, unit offset)
	function automatic logic [NODE_W-1:0] node_of(input logic [LVL_W-1:0] lvl,
			input logic [UNIT_W-1:0] unit);
		logic [NODE_W-1:0] base;
		base = NODE_W'(1) << (LVL_W'(MAX_LEVEL) - lvl);
		return base + NODE_W'(unit >> lvl);
	endfunction

	// first and last bitmap word holding the nodes of a level
	function automatic logic [WADDR_W-1:0] first_word(input logic [LVL_W-1:0] lvl);
		logic [NODE_W-1:0] base;
		base = NODE_W'(1) << (LVL_W'(MAX_LEVEL) - lvl);
		return base[NODE_W-1:BIT_W];
	endfunction

	function automatic logic [WADDR_W-1:0] last_word(input logic [LVL_W-1:0] lvl);
		logic [NODE_W-1:0] top;
		top = (NODE_W'(2) << (LVL_W'(MAX_LEVEL) - lvl)) - NODE_W'(1);
		return top[NODE_W-1:BIT_W];
	endfunction

endpackage

`default_nettype wire

### hdl/bba_need.sv
// bba_need: smallest block level that covers a request plus its header
// depends on bba_pkg
`default_nettype none

module bba_need import bba_pkg::*; (
	input  wire logic [31:0]      request_bytes,
	output logic      [LVL_W-1:0] need
);

	logic [32:0] total;

	assign total = {1'b0, request_bytes} + 33'(HEADER_BYTES);

	// 11 independent compares, lowest fitting level wins; 11 means too large
	always_comb begin
		need = LVL_W'(MAX_LEVEL + 1);
		for (int l = MAX_LEVEL; l >= 0; l--) begin
			if (total <= (33'(UNIT_BYTES) << l)) begin
				need = LVL_W'(l);
			end
		end
	end

endmodule

`default_nettype wire

### hdl/buddy_block_allocator.sv
// buddy_block_allocator: binary buddy allocator over a pool of 1 KiB units
// depends on bba_pkg and bba_need
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------
//  request  | start / busy       | kind, request_bytes, block_unit
//  result   | done (strobe)      | status, result_unit, result_level
//  config   | cfg_we             | cfg_wdata (pool level)
//
// a request is taken when start is high and busy low; one result per request
// an allocate is accepted, then reads and checks each bitmap word scanned (up to 68 words
// over all levels), does a read-modify-write per split and finishes; a free is accepted,
// looks up the owner, reads and checks the buddy per merge step and marks the final block.
// the bitmap memory has a registered read, so every check follows its read
// after reset and after every config transfer a clearing pass sweeps both memories,
// with busy held high
// the receiver cannot stall: done is high for exactly one cycle
`default_nettype none

module buddy_block_allocator import bba_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              kind,
	input  wire logic [31:0]       request_bytes,
	input  wire logic [UNIT_W-1:0] block_unit,
	output logic                   done,
	output logic [1:0]             status,
	output logic [UNIT_W-1:0]      result_unit,
	output logic [LVL_W-1:0]       result_level,
	input  wire logic              cfg_we,
	input  wire logic [3:0]        cfg_wdata
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_SPLIT,
		S_SET_RD,
		S_SET_WR,
		S_OWN_RD,
		S_OWN_CHK,
		S_MERGE,
		S_BUD_RD,
		S_BUD_CHK
	} state_t;

	state_t               state_q;
	logic [UNIT_W-1:0]    clr_q;
	logic [LVL_W-1:0]     pool_q;
	logic                 kind_q;
	logic [WADDR_W-1:0]   w_q;
	logic [BIT_W-1:0]     b_q;
	logic [UNIT_W-1:0]    u_q;
	logic [LVL_W-1:0]     lvl_q;
	logic [LVL_W-1:0]     need_q;
	logic                 done_q;
	status_t              status_q;
	logic [UNIT_W-1:0]    unit_q;
	logic [LVL_W-1:0]     level_q;

	// free-mark bitmap: 64 words of 32 nodes; owned levels: level + 1, 0 if none
	logic [WORD_BITS-1:0] fm_mem [WORDS];
	logic [LVL_W-1:0]     om_mem [UNITS];
	logic [WORD_BITS-1:0] fm_rd;
	logic [LVL_W-1:0]     om_rd;

	logic                 fm_we;
	logic [WADDR_W-1:0]   fm_wa;
	logic [WORD_BITS-1:0] fm_wd;
	logic                 om_we;
	logic [UNIT_W-1:0]    om_wa;
	logic [LVL_W-1:0]     om_wd;

	logic [LVL_W-1:0]     need;
	logic [LVL_W-1:0]     cfg_sat;
	logic [NODE_W-1:0]    pool_node;
	logic [NODE_W-1:0]    lvl_base;
	logic [WORD_BITS-1:0] hit;
	logic                 hit_any;
	logic [BIT_W-1:0]     hit_b;
	logic [NODE_W-1:0]    hit_node;
	logic [UNIT_W-1:0]    hit_unit;
	logic [UNIT_W-1:0]    lvl_bit;
	logic [UNIT_W-1:0]    split_bit;
	logic [NODE_W-1:0]    split_node;
	logic [NODE_W-1:0]    bud_node;
	logic [NODE_W-1:0]    own_node;
	logic                 accept;

	bba_need u_need (
		.request_bytes (request_bytes),
		.need          (need)
	);

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign cfg_sat = (cfg_wdata > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : cfg_wdata;

	assign done         = done_q;
	assign status       = status_q;
	assign result_unit  = unit_q;
	assign result_level = level_q;

	// node arithmetic for the current level
	assign pool_node  = node_of(pool_q, '0);
	assign lvl_base   = NODE_W'(1) << (LVL_W'(MAX_LEVEL) - lvl_q);
	assign lvl_bit    = UNIT_W'(1) << lvl_q;
	assign split_bit  = UNIT_W'(1) << (lvl_q - LVL_W'(1));
	assign split_node = node_of(lvl_q - LVL_W'(1), u_q ^ split_bit);
	assign bud_node   = node_of(lvl_q, u_q ^ lvl_bit);
	assign own_node   = node_of(lvl_q, u_q);

	// nodes of the scanned word that belong to the level and are free
	// one extra bit so the end of level 0 does not wrap
	always_comb begin
		hit   = '0;
		hit_b = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if ({1'b0, w_q, BIT_W'(b)} >= {1'b0, lvl_base} &&
					{1'b0, w_q, BIT_W'(b)} < ({1'b0, lvl_base} << 1)) begin
				hit[b] = fm_rd[b];
			end
		end
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (hit[b]) begin
				hit_b = BIT_W'(b);
			end
		end
	end

	assign hit_any  = |hit;
	assign hit_node = {w_q, hit_b};
	assign hit_unit = UNIT_W'((hit_node - lvl_base) << lvl_q);

	// memory write port selection
	always_comb begin
		fm_we = 1'b0;
		fm_wa = w_q;
		fm_wd = fm_rd;
		om_we = 1'b0;
		om_wa = u_q;
		om_wd = '0;
		case (state_q)
			S_CLEAR: begin
				om_we = 1'b1;
				om_wa = clr_q;
				fm_we = (clr_q < UNIT_W'(WORDS));
				fm_wa = clr_q[WADDR_W-1:0];
				fm_wd = (clr_q[WADDR_W-1:0] == pool_node[NODE_W-1:BIT_W])
					? (WORD_BITS'(1) << pool_node[BIT_W-1:0]) : '0;
			end
			S_SRCH_CHK: begin
				// taking the found block off the free marks
				fm_we = hit_any;
				fm_wd = fm_rd & ~(WORD_BITS'(1) << hit_b);
			end
			S_SPLIT: begin
				om_we = !(lvl_q > need_q);
				om_wd = need_q + LVL_W'(1);
			end
			S_SET_WR: begin
				fm_we = 1'b1;
				fm_wd = fm_rd | (WORD_BITS'(1) << b_q);
			end
			S_OWN_CHK: begin
				om_we = (om_rd != '0);
			end
			S_BUD_CHK: begin
				// buddy free: absorb it; else mark own node, the pair shares a word
				fm_we = 1'b1;
				fm_wd = fm_rd[b_q] ? (fm_rd & ~(WORD_BITS'(1) << b_q))
					: (fm_rd | (WORD_BITS'(1) << (b_q ^ BIT_W'(1))));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fm_we) begin
			fm_mem[fm_wa] <= fm_wd;
		end
		fm_rd <= fm_mem[w_q];
	end

	always_ff @(posedge clk) begin
		if (om_we) begin
			om_mem[om_wa] <= om_wd;
		end
		om_rd <= om_mem[u_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			pool_q   <= LVL_W'(MAX_LEVEL);
			kind_q   <= 1'b0;
			w_q      <= '0;
			b_q      <= '0;
			u_q      <= '0;
			lvl_q    <= '0;
			need_q   <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			unit_q   <= '0;
			level_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				// new pool level restarts the sweep
				pool_q  <= cfg_sat;
				clr_q   <= '0;
				state_q <= S_CLEAR;
			end else begin
				case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + UNIT_W'(1);
						if (clr_q == UNIT_W'(UNITS - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (accept) begin
							kind_q <= kind;
							need_q <= need;
							u_q    <= block_unit;
							if (kind) begin
								state_q <= S_OWN_RD;
							end else if (request_bytes == '0) begin
								done_q   <= 1'b1;
								status_q <= ST_ZERO;
								unit_q   <= '0;
								level_q  <= '0;
							end else if (need > pool_q) begin
								done_q   <= 1'b1;
								status_q <= ST_NO_SPACE;
								unit_q   <= '0;
								level_q  <= '0;
							end else begin
								lvl_q   <= need;
								w_q     <= first_word(need);
								state_q <= S_SRCH_RD;
							end
						end
					end
					S_SRCH_RD: begin
						state_q <= S_SRCH_CHK;
					end
					S_SRCH_CHK: begin
						if (hit_any) begin
							u_q     <= hit_unit;
							state_q <= S_SPLIT;
						end else if (w_q == last_word(lvl_q)) begin
							if (lvl_q >= pool_q) begin
								done_q   <= 1'b1;
								status_q <= ST_NO_SPACE;
								unit_q   <= '0;
								level_q  <= '0;
								state_q  <= S_IDLE;
							end else begin
								lvl_q   <= lvl_q + LVL_W'(1);
								w_q     <= first_word(lvl_q + LVL_W'(1));
								state_q <= S_SRCH_RD;
							end
						end else begin
							w_q     <= w_q + WADDR_W'(1);
							state_q <= S_SRCH_RD;
						end
					end
					S_SPLIT: begin
						if (lvl_q > need_q) begin
							// upper half of each split becomes free
							w_q     <= split_node[NODE_W-1:BIT_W];
							b_q     <= split_node[BIT_W-1:0];
							lvl_q   <= lvl_q - LVL_W'(1);
							state_q <= S_SET_RD;
						end else begin
							done_q   <= 1'b1;
							status_q <= ST_OK;
							unit_q   <= u_q;
							level_q  <= need_q;
							state_q  <= S_IDLE;
						end
					end
					S_SET_RD: begin
						state_q <= S_SET_WR;
					end
					S_SET_WR: begin
						if (!kind_q) begin
							state_q <= S_SPLIT;
						end else begin
							done_q   <= 1'b1;
							status_q <= ST_OK;
							unit_q   <= u_q;
							level_q  <= lvl_q;
							state_q  <= S_IDLE;
						end
					end
					S_OWN_RD: begin
						state_q <= S_OWN_CHK;
					end
					S_OWN_CHK: begin
						if (om_rd == '0) begin
							done_q   <= 1'b1;
							status_q <= ST_BAD_FREE;
							unit_q   <= '0;
							level_q  <= '0;
							state_q  <= S_IDLE;
						end else begin
							lvl_q   <= om_rd - LVL_W'(1);
							state_q <= S_MERGE;
						end
					end
					S_MERGE: begin
						if (lvl_q < pool_q) begin
							w_q     <= bud_node[NODE_W-1:BIT_W];
							b_q     <= bud_node[BIT_W-1:0];
							state_q <= S_BUD_RD;
						end else begin
							w_q     <= own_node[NODE_W-1:BIT_W];
							b_q     <= own_node[BIT_W-1:0];
							state_q <= S_SET_RD;
						end
					end
					S_BUD_RD: begin
						state_q <= S_BUD_CHK;
					end
					S_BUD_CHK: begin
						if (fm_rd[b_q]) begin
							u_q     <= u_q & ~lvl_bit;
							lvl_q   <= lvl_q + LVL_W'(1);
							state_q <= S_MERGE;
						end else begin
							done_q   <= 1'b1;
							status_q <= ST_OK;
							unit_q   <= u_q;
							level_q  <= lvl_q;
							state_q  <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

`ifndef ASSERT_OFF
	// a result is only ever strobed once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	// error results carry zero fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (result_unit == '0 && result_level == '0))
		else $error("error result with nonzero fields");

	// a granted or merged block never exceeds the pool
	a_lvl_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OK) |-> (result_level <= pool_q))
		else $error("result level above pool level");
`endif

endmodule

`default_nettype wire

### sim/tb_buddy_block_allocator.sv
// tb_buddy_block_allocator: self-checking testbench for the buddy block allocator
// depends on bba_pkg (status codes) and the buddy_block_allocator rtl

module tb_buddy_block_allocator;
	import bba_pkg::*;

	typedef struct {
		logic        kind;
		logic [31:0] bytes;
		logic [9:0]  unit;
	} alloc_req_t;

	typedef struct {
		status_t    st;
		logic [9:0] unit;
		logic [3:0] lvl;
	} alloc_res_t;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start;
	logic        kind;
	logic [31:0] request_bytes;
	logic [9:0]  block_unit;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_wdata = 4'd0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [9:0]  result_unit;
	logic [3:0]  result_level;

	buddy_block_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .request_bytes(request_bytes), .block_unit(block_unit),
		.done(done), .status(status), .result_unit(result_unit),
		.result_level(result_level), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// shadow of the allocator: one free bit per tree node, owned level + 1 per unit
	logic       node_free [0:2047];
	logic [4:0] unit_owner [0:1023];
	int         pool_lvl;
	int         live_blocks[$];

	alloc_req_t pending_reqs[$];
	alloc_res_t expected_results[$];
	int         mismatch_count = 0;
	int         gap_left = 0;
	bit         burst_mode = 0;
	alloc_req_t cur_req;

	function automatic int node_idx(int lvl, int unit);
		return ((1 << (10 - lvl)) + (unit >> lvl)) & 2047;
	endfunction

	function automatic void clear_pool(int lvl);
		for (int i = 0; i < 2048; i++) node_free[i] = 1'b0;
		for (int i = 0; i < 1024; i++) unit_owner[i] = 5'd0;
		pool_lvl = lvl;
		node_free[node_idx(lvl, 0)] = 1'b1;
		live_blocks.delete();
	endfunction

	function automatic void forget_block(int unit);
		for (int i = 0; i < live_blocks.size(); i++)
			if (live_blocks[i] == unit) begin
				live_blocks.delete(i);
				break;
			end
	endfunction

	// work out the result of one request and update the shadow state
	function automatic alloc_res_t buddy_predict(alloc_req_t req);
		alloc_res_t res;
		logic [63:0] total;
		int need, k, off, u, lvl, buddy;
		bit found;
		res.st = ST_OK;
		res.unit = '0;
		res.lvl = '0;
		found = 0;
		off = 0;
		k = 0;
		if (req.kind == KIND_ALLOC) begin
			if (req.bytes == 0) begin
				res.st = ST_ZERO;
				return res;
			end
			total = 64'(req.bytes) + 64'd16;
			need = 0;
			while (need <= 10 && (64'd1024 << need) < total) need++;
			if (need > pool_lvl) begin
				res.st = ST_NO_SPACE;
				return res;
			end
			// smallest level first, lowest address within it
			for (k = need; k <= pool_lvl && !found; k++) begin
				for (off = 0; off < (1 << pool_lvl); off += (1 << k))
					if (node_free[node_idx(k, off)]) begin
						found = 1;
						break;
					end
				if (found) break;
			end
			if (!found) begin
				res.st = ST_NO_SPACE;
				return res;
			end
			node_free[node_idx(k, off)] = 1'b0;
			// split: every upper half becomes free
			for (int j = k; j > need; j--)
				node_free[node_idx(j - 1, off ^ (1 << (j - 1)))] = 1'b1;
			unit_owner[off] = 5'(need + 1);
			live_blocks.push_back(off);
			res.unit = 10'(off);
			res.lvl = 4'(need);
		end else begin
			u = req.unit;
			if (unit_owner[u] == 0) begin
				res.st = ST_BAD_FREE;
				return res;
			end
			forget_block(u);
			lvl = unit_owner[u] - 1;
			unit_owner[u] = 5'd0;
			// merge with the free buddy, never above the pool
			while (lvl < pool_lvl) begin
				buddy = u ^ (1 << lvl);
				if (!node_free[node_idx(lvl, buddy)]) break;
				node_free[node_idx(lvl, buddy)] = 1'b0;
				if (buddy < u) u = buddy;
				lvl++;
			end
			node_free[node_idx(lvl, u)] = 1'b1;
			res.unit = 10'(u);
			res.lvl = 4'(lvl);
		end
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: one transfer per start/busy handshake, gaps drawn after each transfer
	always @(posedge clk or negedge arst_n) begin
		bit presenting;
		if (!arst_n) begin
			start <= 1'b0;
			kind <= KIND_ALLOC;
			request_bytes <= '0;
			block_unit <= '0;
		end else begin
			presenting = start;
			if (start && !busy) begin
				expected_results.push_back(buddy_predict(cur_req));
				presenting = 0;
				gap_left = pick_gap();
			end
			if (!presenting) begin
				if (gap_left > 0)
					gap_left--;
				else if (pending_reqs.size() > 0 && !cfg_we) begin
					cur_req = pending_reqs.pop_front();
					presenting = 1;
				end
			end
			start <= presenting;
			kind <= cur_req.kind;
			request_bytes <= cur_req.bytes;
			block_unit <= cur_req.unit;
		end
	end

	// monitor: every done strobe is a result transfer, checked against the oldest expectation
	always @(posedge clk) begin
		alloc_res_t exp_res;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: status %0d unit %0d level %0d",
						status, result_unit, result_level);
			end else begin
				exp_res = expected_results.pop_front();
				if (status !== exp_res.st || result_unit !== exp_res.unit ||
						result_level !== exp_res.lvl) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected status %0d unit %0d level %0d, got %0d %0d %0d",
							exp_res.st, exp_res.unit, exp_res.lvl,
							status, result_unit, result_level);
				end
			end
		end
	end

	task automatic queue_alloc(logic [31:0] bytes);
		alloc_req_t r;
		r.kind = KIND_ALLOC;
		r.bytes = bytes;
		r.unit = 10'($urandom);
		pending_reqs.push_back(r);
	endtask

	task automatic queue_free(logic [9:0] unit);
		alloc_req_t r;
		r.kind = KIND_FREE;
		r.bytes = $urandom;
		r.unit = unit;
		pending_reqs.push_back(r);
	endtask

	// wait until every queued transfer has been taken and answered
	task automatic drain();
		while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// config transfer while idle; the block then clears its store with busy high
	task automatic set_pool(logic [3:0] lvl);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= lvl;
		@(posedge clk);
		cfg_we <= 1'b0;
		clear_pool(lvl > 10 ? 10 : int'(lvl));
	endtask

	// mostly well-formed: sized allocations and frees of live blocks, some noise
	task automatic queue_random(int count);
		int r, l;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50 || (r < 82 && live_blocks.size() == 0)) begin
				l = $urandom_range(0, pool_lvl < 10 ? pool_lvl + 1 : 10);
				if (l == 0) queue_alloc($urandom_range(1, 1008));
				else queue_alloc($urandom_range((1024 << (l - 1)) - 15, (1024 << l) - 16));
			end else if (r < 82)
				queue_free(10'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]));
			else if (r < 90) queue_free(10'($urandom));
			else if (r < 96) queue_alloc($urandom);
			else queue_alloc(32'd0);
		end
	endtask

	initial begin
		int lvls[6];
		clear_pool(10);
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: zero, huge, exact fits, whole pool, full pool, merges, bad frees
		queue_alloc(32'd0);
		queue_alloc(32'hFFFF_FFFF);
		queue_alloc(32'd1008);
		queue_alloc(32'd1009);
		queue_free(10'd0);
		queue_free(10'd2);
		queue_free(10'd2);
		queue_alloc(32'd1048560);
		queue_alloc(32'd1);
		queue_free(10'd0);
		queue_alloc(32'd1048561);
		queue_alloc(32'd1);
		queue_alloc(32'd1);
		queue_alloc(32'd1);
		queue_free(10'd1);
		queue_free(10'd0);
		queue_free(10'd2);
		queue_free(10'd1023);
		set_pool(4'd0);
		queue_alloc(32'd1008);
		queue_alloc(32'd1);
		queue_free(10'd5);
		queue_free(10'd0);
		set_pool(4'd15);
		queue_alloc(32'd1048560);
		queue_free(10'd0);

		lvls = '{10, 0, 15, 3, 1, 10};
		foreach (lvls[p]) begin
			set_pool(4'(lvls[p]));
			for (int b = 0; b < 40; b++) begin
				burst_mode = ($urandom_range(0, 5) == 0);
				queue_random(8);
				drain();
			end
		end
		burst_mode = 0;
		set_pool(4'($urandom_range(0, 15)));
		queue_random(40);
		drain();
		repeat (300) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#40000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
